// ===== rtl/core/huffman_code_bit_packer_unit_macros.svh =====
// Assertion macros for the Huffman code bit packer.
// Included by the RTL modules that carry assertions; no other dependencies.
`ifndef HUFFMAN_CODE_BIT_PACKER_UNIT_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define HCBP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hcbp assertion failed");

// Condition that must never be true outside reset.
`define HCBP_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("hcbp forbidden condition seen");

`else

`define HCBP_ASSERT(label, clk, rst_n, prop)
`define HCBP_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== rtl/core/hcbp_pkg.sv =====
// Shared types and constants for the Huffman code bit packer.
// No dependencies; used by hcbp_packer and huffman_code_bit_packer_unit.
package hcbp_pkg;

    // Default longest code word the table can hold.
    localparam int MAX_CODE_LEN_DEFAULT = 32;

    // Table depth follows the symbol field width.
    localparam int SYM_W = 8;

    // Request operation codes.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    // Packer sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } pk_state_t;

    // Accepted request as seen by the packer.
    typedef struct packed {
        logic encode;
        logic flush;
    } pk_req_t;

endpackage

// ===== rtl/core/hcbp_code_mem.sv =====
// Code table memory: one write port, one read port, registered read data.
// Depends on nothing; instantiated by huffman_code_bit_packer_unit.
module hcbp_code_mem #(
    parameter int DATA_W = 38,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/hcbp_packer.sv =====
// Bit accumulator and byte sequencer of the Huffman code bit packer.
// Depends on hcbp_pkg and huffman_code_bit_packer_unit_macros.svh.
`include "huffman_code_bit_packer_unit_macros.svh"

module hcbp_packer #(
    parameter int CODE_W = 32,
    parameter int LEN_W  = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hcbp_pkg::pk_req_t req,
    input  logic [CODE_W-1:0] rd_code,
    input  logic [LEN_W-1:0]  rd_len,
    output logic              busy,
    output logic              strobe,
    output logic [7:0]        packed_byte,
    output logic              last_of_run
);

    localparam int ACC_W  = CODE_W + 8;
    localparam int BITS_W = $clog2(CODE_W + 8);

    hcbp_pkg::pk_state_t state_reg, state_next;

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [BITS_W-1:0] bits_reg, bits_next;
    logic [7:0]        pend_reg, pend_next;   // pending bits, left aligned
    logic [2:0]        pcnt_reg, pcnt_next;
    logic              strobe_reg, strobe_next;
    logic [7:0]        byte_reg, byte_next;
    logic              last_reg, last_next;

    logic [ACC_W-1:0]  acc_calc;
    logic [BITS_W-1:0] total;

    // Merge the looked-up code behind the pending bits.
    assign acc_calc = {pend_reg, {CODE_W{1'b0}}} | ({rd_code, 8'h00} >> pcnt_reg);
    assign total    = BITS_W'(pcnt_reg) + BITS_W'(rd_len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hcbp_pkg::ST_IDLE;
            pend_reg   <= 8'h00;
            pcnt_reg   <= 3'd0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            pcnt_reg   <= pcnt_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        bits_reg <= bits_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        bits_next   = bits_reg;
        pend_next   = pend_reg;
        pcnt_next   = pcnt_reg;
        strobe_next = 1'b0;
        byte_next   = byte_reg;
        last_next   = last_reg;
        unique case (state_reg)
            hcbp_pkg::ST_IDLE:
            begin
                if (req.encode)
                begin
                    state_next = hcbp_pkg::ST_LOOKUP;
                end
                else if (req.flush && (pcnt_reg != 3'd0))
                begin
                    strobe_next = 1'b1;
                    byte_next   = pend_reg;
                    last_next   = 1'b1;
                    pend_next   = 8'h00;
                    pcnt_next   = 3'd0;
                end
            end
            hcbp_pkg::ST_LOOKUP:
            begin
                if (total < BITS_W'(8))
                begin
                    pend_next  = acc_calc[ACC_W-1 -: 8];
                    pcnt_next  = total[2:0];
                    state_next = hcbp_pkg::ST_IDLE;
                end
                else
                begin
                    acc_next   = acc_calc;
                    bits_next  = total;
                    state_next = hcbp_pkg::ST_EMIT;
                end
            end
            hcbp_pkg::ST_EMIT:
            begin
                strobe_next = 1'b1;
                byte_next   = acc_reg[ACC_W-1 -: 8];
                last_next   = ({1'b0, bits_reg} < (BITS_W+1)'(16));
                acc_next    = acc_reg << 8;
                bits_next   = bits_reg - BITS_W'(8);
                if (last_next)
                begin
                    pend_next  = acc_reg[ACC_W-9 -: 8];
                    pcnt_next  = bits_reg[2:0];
                    state_next = hcbp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hcbp_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != hcbp_pkg::ST_IDLE);
    assign strobe      = strobe_reg;
    assign packed_byte = byte_reg;
    assign last_of_run = last_reg;

    // Bytes of one run leave on consecutive cycles.
    `HCBP_ASSERT(a_run_contiguous, clk, rst_n, (strobe_reg && !last_reg) |=> strobe_reg)
    // A lookup follows only an accepted encode request.
    `HCBP_ASSERT(a_lookup_after_encode, clk, rst_n,
                 (state_reg == hcbp_pkg::ST_LOOKUP) |-> $past(req.encode))
    // Emission never starts with less than a full byte.
    `HCBP_ASSERT_NEVER(a_emit_underflow, clk, rst_n,
                       (state_reg == hcbp_pkg::ST_EMIT) && (bits_reg < BITS_W'(8)))
    // A run ends with the block ready for the next request.
    `HCBP_ASSERT(a_last_frees_block, clk, rst_n,
                 (strobe_reg && last_reg) |-> (state_reg == hcbp_pkg::ST_IDLE))

endmodule

// ===== rtl/core/huffman_code_bit_packer_unit.sv =====
// Top level of the Huffman code bit packer: request decode and table load path.
// Depends on hcbp_pkg, hcbp_code_mem and hcbp_packer.
//
// A request is taken at a rising edge with start high and busy low. A load
// request writes the code table in that same cycle and leaves busy low, so a
// new request can follow on the next cycle. An encode request reads the
// table (synchronous memory), merges the code behind the pending bits,
// then puts out one completed byte per cycle; busy stays high through the
// lookup and the emission of the N bytes completed (0 to 4). A flush
// request leaves busy low and emits the padded byte only when bits are
// pending. Each byte appears on packed_byte for exactly one cycle with
// strobe high, in the cycle after it is formed; last_of_run marks the
// final byte a request causes. The receiver cannot stall: sample every
// strobe. Table entries have no reset; encode only symbols whose entries
// have been loaded. Code lengths above MAX_CODE_LEN (or 32) are saturated;
// code bits above the length are dropped.
module huffman_code_bit_packer_unit #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [7:0]  symbol,
    input  logic [31:0] code_word,
    input  logic [5:0]  code_length,
    output logic        strobe,
    output logic [7:0]  packed_byte,
    output logic        last_of_run
);

    // Stored code width: the port never carries more than 32 code bits.
    localparam int CODE_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
    localparam int LEN_W  = $clog2(CODE_W + 1);
    localparam int DATA_W = CODE_W + LEN_W;

    logic              accept;
    hcbp_pkg::pk_req_t req;
    logic              wr_en;
    logic              rd_en;
    logic [LEN_W-1:0]  len_sat;
    logic [CODE_W-1:0] code_lj;
    logic [DATA_W-1:0] rd_data;

    assign accept = start && !busy;

    assign req = '{encode: accept && (operation == hcbp_pkg::OP_ENCODE),
                   flush:  accept && (operation == hcbp_pkg::OP_FLUSH)};

    assign wr_en = accept && (operation == hcbp_pkg::OP_LOAD);
    assign rd_en = req.encode;

    // Saturate the length, then left-align the code so its first bit sits at
    // the top; shifting left also drops stray bits above the length.
    assign len_sat = (code_length > 6'(CODE_W)) ? LEN_W'(CODE_W) : code_length[LEN_W-1:0];
    assign code_lj = code_word[CODE_W-1:0] << (LEN_W'(CODE_W) - len_sat);

    hcbp_code_mem #(
        .DATA_W (DATA_W),
        .ADDR_W (hcbp_pkg::SYM_W)
    ) u_code_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (symbol),
        .wr_data ({len_sat, code_lj}),
        .rd_en   (rd_en),
        .rd_addr (symbol),
        .rd_data (rd_data)
    );

    hcbp_packer #(
        .CODE_W (CODE_W),
        .LEN_W  (LEN_W)
    ) u_packer (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rd_code     (rd_data[CODE_W-1:0]),
        .rd_len      (rd_data[DATA_W-1 -: LEN_W]),
        .busy        (busy),
        .strobe      (strobe),
        .packed_byte (packed_byte),
        .last_of_run (last_of_run)
    );

endmodule

// ===== test/hcbp_packing_checker.sv =====
// Checker for the Huffman code bit packer: mirrors the code table and bit accumulator.
// It predicts every packed byte and compares it with the strobed output.
// Depends on hcbp_pkg only.
module hcbp_packing_checker #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  operation,
    input  logic [7:0]  symbol,
    input  logic [31:0] code_word,
    input  logic [5:0]  code_length,
    input  logic        strobe,
    input  logic [7:0]  packed_byte,
    input  logic        last_of_run,
    output int          mismatch_count,
    output int          bytes_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import hcbp_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } packed_out_t;

    logic [31:0]  code_bits [256];
    logic [5:0]   code_len [256];
    logic [6:0]   held_bits;
    logic [2:0]   held_count;
    packed_out_t  expected_bytes [$];
    int           errors;

    task automatic note_mismatch(input string what, input packed_out_t want,
                                 input packed_out_t got);
        errors++;
        if (errors <= 10)
            $display("%0t mismatch (%s): expected byte %02h last %0d, got byte %02h last %0d",
                     $realtime, what, want.data, want.last, got.data, got.last);
    endtask

    // Apply one request to the mirrored state and queue the bytes it completes.
    task automatic pack_request(input logic [1:0] op, input logic [7:0] sym,
                                input logic [31:0] cw, input logic [5:0] len);
        int           lim;
        int           width;
        int           total;
        int           nbytes;
        int           k;
        logic [63:0]  acc;
        logic [63:0]  mask;
        logic [15:0]  padded;
        packed_out_t  item;
        lim = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
        case (op)
            OP_LOAD:
            begin
                width = (int'(len) > lim) ? lim : int'(len);
                mask = (64'd1 << width) - 64'd1;
                code_bits[sym] = cw & mask[31:0];
                code_len[sym] = 6'(width);
            end
            OP_ENCODE:
            begin
                width = int'(code_len[sym]);
                total = int'(held_count) + width;
                acc = ({57'd0, held_bits} << width) | {32'd0, code_bits[sym]};
                nbytes = total / 8;
                for (k = 0; k < nbytes; k++)
                begin
                    item.data = 8'(acc >> (total - 8 * (k + 1)));
                    item.last = (k == nbytes - 1);
                    expected_bytes.push_back(item);
                end
                held_count = 3'(total % 8);
                mask = (64'd1 << held_count) - 64'd1;
                held_bits = 7'(acc & mask);
            end
            OP_FLUSH:
            begin
                if (held_count != 3'd0)
                begin
                    padded = {9'd0, held_bits} << (8 - int'(held_count));
                    item.data = padded[7:0];
                    item.last = 1'b1;
                    expected_bytes.push_back(item);
                    held_bits = '0;
                    held_count = '0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        packed_out_t want;
        packed_out_t got;
        if (!rst_n)
        begin
            expected_bytes.delete();
            held_bits = '0;
            held_count = '0;
            errors = 0;
            mismatch_count <= 0;
            bytes_outstanding <= 0;
        end
        else
        begin
            // Compare before predicting: a byte never leaves in its own accept cycle.
            if (strobe)
            begin
                got.data = packed_byte;
                got.last = last_of_run;
                if (expected_bytes.size() == 0)
                begin
                    want = '0;
                    note_mismatch("unexpected byte", want, got);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (got.data !== want.data || got.last !== want.last)
                        note_mismatch("wrong byte", want, got);
                end
            end
            if (start && !busy)
                pack_request(operation, symbol, code_word, code_length);
            mismatch_count <= errors;
            bytes_outstanding <= expected_bytes.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for huffman_code_bit_packer_unit: drives requests and gives the verdict.
// Depends on hcbp_pkg, the packer RTL and hcbp_packing_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hcbp_pkg::*;

    // Cycles with neither an accepted request nor a strobed byte before giving up.
    localparam int STALL_LIMIT = 500;
    // Requests per idling phase; op 3 requests are not counted.
    localparam int PHASE_REQUESTS = 38;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic [7:0]  symbol;
    logic [31:0] code_word;
    logic [5:0]  code_length;
    logic        strobe;
    logic [7:0]  packed_byte;
    logic        last_of_run;
    int          mismatch_count;
    int          bytes_outstanding;

    // Track which table entries hold a code so encodes never hit an empty entry.
    bit          entry_loaded [256];
    logic [7:0]  loaded_syms [$];

    // Sender idle percentage per phase: none, heavy, none again, moderate.
    int          idle_pct [4] = '{0, 72, 0, 36};
    int          quiet_cycles;

    huffman_code_bit_packer_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .symbol      (symbol),
        .code_word   (code_word),
        .code_length (code_length),
        .strobe      (strobe),
        .packed_byte (packed_byte),
        .last_of_run (last_of_run)
    );

    hcbp_packing_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .operation         (operation),
        .symbol            (symbol),
        .code_word         (code_word),
        .code_length       (code_length),
        .strobe            (strobe),
        .packed_byte       (packed_byte),
        .last_of_run       (last_of_run),
        .mismatch_count    (mismatch_count),
        .bytes_outstanding (bytes_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Present one request at the falling edge and hold it until a rising edge
    // sees busy low. Start stays high on return so back-to-back requests do not
    // drop it between items.
    task automatic issue_request(input logic [1:0] op, input logic [7:0] sym,
                                 input logic [31:0] cw, input logic [5:0] len);
        @(negedge clk);
        start <= 1'b1;
        operation <= op;
        symbol <= sym;
        code_word <= cw;
        code_length <= len;
        do
            @(posedge clk);
        while (busy);
        if (op == OP_LOAD && !entry_loaded[sym])
        begin
            entry_loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
    endtask

    // Drop start for a number of cycles; scramble the fields so the block
    // must ignore them while start is low.
    task automatic hold_off(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        operation <= 2'($urandom);
        symbol <= 8'($urandom);
        code_word <= $urandom;
        code_length <= 6'($urandom);
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Hold the sender until every predicted byte has been seen.
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (bytes_outstanding != 0)
            @(negedge clk);
    endtask

    // Watchdog: any accepted request or strobed byte counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int          phase;
        int          counted;
        int          sel;
        int          pick;
        int          gap;
        logic [1:0]  op;
        logic [7:0]  sym;
        logic [31:0] cw;
        logic [5:0]  len;

        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_LOAD;
        symbol = '0;
        code_word = '0;
        code_length = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part.
        // Load the table extremes: shortest code, longest code, overlong
        // lengths that must saturate, a zero-length entry, and a short code
        // whose upper code_word bits are stray and must be dropped.
        issue_request(OP_LOAD, 8'h00, 32'h0000_0000, 6'd1);
        issue_request(OP_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
        issue_request(OP_LOAD, 8'h80, 32'hFFFF_FFFF, 6'h3F);
        issue_request(OP_LOAD, 8'h01, 32'hA5A5_A5A5, 6'd0);
        issue_request(OP_LOAD, 8'h7F, 32'hFFFF_FFF5, 6'd3);
        issue_request(OP_LOAD, 8'h55, 32'h8000_0001, 6'd33);
        issue_request(OP_LOAD, 8'h10, 32'h0000_0055, 6'd7);
        // Flush with nothing pending must emit nothing.
        issue_request(OP_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        // Encode fields other than the symbol are junk and must be ignored.
        issue_request(OP_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'h3F);
        issue_request(OP_ENCODE, 8'h01, 32'h0000_0000, 6'd0);
        issue_request(OP_ENCODE, 8'hFF, 32'h1234_5678, 6'd5);
        issue_request(OP_ENCODE, 8'h80, 32'h0, 6'd0);
        issue_request(OP_ENCODE, 8'h7F, 32'h0, 6'd0);
        // The unused operation code must do nothing.
        issue_request(2'd3, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        issue_request(OP_FLUSH, 8'h00, 32'h0, 6'd0);
        // Seven pending bits plus a full 32-bit code: four bytes, seven left.
        issue_request(OP_ENCODE, 8'h10, 32'h0, 6'd0);
        issue_request(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
        issue_request(OP_FLUSH, 8'h55, 32'hFFFF_FFFF, 6'd9);
        issue_request(OP_ENCODE, 8'h55, 32'h0, 6'd0);
        issue_request(OP_ENCODE, 8'h7F, 32'h0, 6'd0);
        issue_request(OP_ENCODE, 8'h7F, 32'h0, 6'd0);
        issue_request(OP_FLUSH, 8'h00, 32'h0, 6'd0);
        // Pause the sender until every byte so far has come out.
        wait_drained();

        // Random part: mostly encodes of loaded symbols, with fresh loads,
        // flushes and ignored requests mixed in.
        for (phase = 0; phase < 4; phase++)
        begin
            counted = 0;
            while (counted < PHASE_REQUESTS)
            begin
                sel = $urandom_range(99);
                cw = $urandom;
                sym = 8'($urandom);
                len = 6'($urandom);
                if (sel < 20)
                begin
                    op = OP_LOAD;
                    // Mostly short codes, some long, some empty, some overlong.
                    pick = $urandom_range(99);
                    if (pick < 55)
                        len = 6'($urandom_range(1, 10));
                    else if (pick < 80)
                        len = 6'($urandom_range(11, 32));
                    else if (pick < 88)
                        len = 6'd0;
                    else
                        len = 6'($urandom_range(33, 63));
                end
                else if (sel < 78)
                begin
                    op = OP_ENCODE;
                    sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
                end
                else if (sel < 94)
                    op = OP_FLUSH;
                else
                    op = 2'd3;
                issue_request(op, sym, cw, len);
                if (op != 2'd3)
                    counted++;
                // Idle each following cycle with the phase's probability.
                gap = 0;
                while ($urandom_range(99) < idle_pct[phase])
                    gap++;
                if (gap > 0)
                    hold_off(gap);
                if ($urandom_range(99) < 3)
                    wait_drained();
            end
            wait_drained();
        end

        // Drain, then give the output register time to settle.
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && bytes_outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
